### sv/tlb2l_pkg.sv
// Shared types and constants for the two-level translating TLB.
// Used by the channel interfaces and by the top level; depends on nothing.
package tlb2l_pkg;

    typedef logic [1:0] t_func;
    localparam t_func FUNC_LOOKUP = 2'd0;
    localparam t_func FUNC_FILL   = 2'd1;
    localparam t_func FUNC_FLUSH  = 2'd2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_PAGE_SIZE      = 3'd0;
    localparam t_cfg_idx CFG_LEVEL1_ROWS    = 3'd1;
    localparam t_cfg_idx CFG_LRU_MODE       = 3'd2;
    localparam t_cfg_idx CFG_ENTRIES_IN_USE = 3'd3;
    localparam t_cfg_idx CFG_ROOT_TABLE     = 3'd4;

    localparam int PSIZE_W   = 17;
    localparam int ROWS_W    = 13;
    localparam int ENTRIES_W = 5;
    localparam int ROOT_W    = 16;
    localparam int OFFSET_W  = 16;
    localparam int L2_W      = 12;
    localparam int AGE_W     = 32;
    localparam int DIV_W     = 17;

    localparam logic [PSIZE_W-1:0] PSIZE_MAX   = 17'd65536;
    localparam logic [PSIZE_W-1:0] PSIZE_RESET = 17'd64;
    localparam logic [ROWS_W-1:0]  ROWS_MAX    = 13'd4096;
    localparam logic [ROWS_W-1:0]  ROWS_RESET  = 13'd4;
    localparam logic [ENTRIES_W-1:0] ENTRIES_RESET = 5'd4;

endpackage

### sv/tlb2l_if.sv
// Request, response and configuration channels of the translating TLB.
// Depends on tlb2l_pkg for the operation type and configuration widths.
interface tlb2l_req_if
    import tlb2l_pkg::*;
#(
    parameter int ADDR_BITS  = 32,
    parameter int FRAME_BITS = 16
) ();
    logic                  valid;
    logic                  ready;
    t_func                 func;
    logic [ADDR_BITS-1:0]  logical_address;
    logic [FRAME_BITS-1:0] fill_frame;

    modport source (output valid, func, logical_address, fill_frame, input ready);
    modport sink   (input valid, func, logical_address, fill_frame, output ready);
endinterface

interface tlb2l_rsp_if
    import tlb2l_pkg::*;
#(
    parameter int ADDR_BITS  = 32,
    parameter int FRAME_BITS = 16
) ();
    logic                  valid;
    logic                  ready;
    logic                  hit;
    logic [FRAME_BITS-1:0] frame;
    logic [ADDR_BITS-1:0]  page_number;
    logic [OFFSET_W-1:0]   page_offset;
    logic [ADDR_BITS-1:0]  level1_index;
    logic [L2_W-1:0]       level2_index;
    logic [ROOT_W-1:0]     walk_root;

    modport source (output valid, hit, frame, page_number, page_offset, level1_index,
                    level2_index, walk_root, input ready);
    modport sink   (input valid, hit, frame, page_number, page_offset, level1_index,
                    level2_index, walk_root, output ready);
endinterface

interface tlb2l_cfg_if
    import tlb2l_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### sv/tlb_two_level_translate_top.sv
// Top level of the fully associative TLB with a two-level walk address split.
// Depends on tlb2l_pkg and on the channel interfaces in tlb2l_if.sv.
//
// Requests arrive on i_req (func, logical_address, fill_frame) and each one gives
// exactly one response on o_rsp. Registers are written on i_cfg, which is always
// ready; they are meant to change only while no request is in flight.
// One request is handled at a time. A single restoring divider, one quotient bit
// per cycle, splits the address by the page size, and on a lookup miss splits the
// page number by the row count. A sequential scan reads one entry per cycle from
// the entry memories to find the page, a free entry and the oldest entry.
// A lookup hit and a fill pass through the address division, the scan over the
// enabled entries and the decide step; a lookup miss then divides the page number
// in a second pass before the final step; a flush goes straight to the final step.
// A new request is taken in the idle state entered as the response is loaded; the response
// register holds the result while the receiver stalls, and a finished request
// waits in its last step until that register is free.
// Reset is synchronous. It clears all valid bits, the use counter and the FIFO
// pointer, empties the response register and restores the register defaults.
module tlb_two_level_translate_top
    import tlb2l_pkg::*;
#(
    parameter int TLB_DEPTH  = 16,
    parameter int ADDR_BITS  = 32,
    parameter int FRAME_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tlb2l_req_if.sink   i_req,
    tlb2l_rsp_if.source o_rsp,
    tlb2l_cfg_if.sink   i_cfg
);

    localparam int IDX_W   = (TLB_DEPTH > 1) ? $clog2(TLB_DEPTH) : 1;
    localparam int CNT_W   = $clog2(TLB_DEPTH + 1);
    localparam int DCNT_W  = $clog2(ADDR_BITS + 1);

    typedef enum logic [2:0] {S_IDLE, S_DIV, S_SCAN, S_DECIDE, S_DONE} t_state;

    typedef struct packed {
        logic                  hit;
        logic [FRAME_BITS-1:0] frame;
        logic [ADDR_BITS-1:0]  page_number;
        logic [OFFSET_W-1:0]   page_offset;
        logic [ADDR_BITS-1:0]  level1_index;
        logic [L2_W-1:0]       level2_index;
        logic [ROOT_W-1:0]     walk_root;
    } t_rsp;

    t_state r_state;

    logic [PSIZE_W-1:0]   r_page_size;
    logic [ROWS_W-1:0]    r_rows;
    logic                 r_lru_mode;
    logic [ENTRIES_W-1:0] r_entries;
    logic [ROOT_W-1:0]    r_root_table;

    t_func                 r_func;
    logic [FRAME_BITS-1:0] r_fill_frame;
    logic [ADDR_BITS-1:0]  r_page;
    logic [OFFSET_W-1:0]   r_offset;

    logic [ADDR_BITS-1:0] r_quo;
    logic [DIV_W-1:0]     r_rem;
    logic [DIV_W-1:0]     r_divisor;
    logic [DCNT_W-1:0]    r_div_cnt;
    logic                 r_div_second;

    logic [TLB_DEPTH-1:0] r_valid;
    logic [IDX_W-1:0]     r_fifo_ptr;
    logic [AGE_W-1:0]     r_use_cnt;

    logic [CNT_W-1:0]      r_idx;
    logic                  r_cmp_vld;
    logic [IDX_W-1:0]      r_cmp_idx;
    logic                  r_found;
    logic [IDX_W-1:0]      r_hit_idx;
    logic [FRAME_BITS-1:0] r_hit_frame;
    logic                  r_free_found;
    logic [IDX_W-1:0]      r_free_idx;
    logic [AGE_W-1:0]      r_min_age;
    logic [IDX_W-1:0]      r_min_idx;

    logic [ADDR_BITS-1:0]  mem_page  [TLB_DEPTH];
    logic [FRAME_BITS-1:0] mem_frame [TLB_DEPTH];
    logic [AGE_W-1:0]      mem_age   [TLB_DEPTH];
    logic [ADDR_BITS-1:0]  r_page_rd;
    logic [FRAME_BITS-1:0] r_frame_rd;
    logic [AGE_W-1:0]      r_age_rd;

    t_rsp r_res;
    t_rsp r_out;
    logic r_out_vld;

    logic [CNT_W-1:0]      w_n;
    logic [PSIZE_W-1:0]    w_psize;
    logic [ROWS_W-1:0]     w_rows;
    logic [DIV_W:0]        w_rem_sh;
    logic [DIV_W:0]        w_diff;
    logic                  w_ge;
    logic [DIV_W-1:0]      w_rem_nx;
    logic [ADDR_BITS-1:0]  w_quo_nx;
    logic                  w_cmp_valid;
    logic                  w_cmp_match;
    logic [IDX_W-1:0]      w_fifo_best;
    logic [CNT_W-1:0]      w_fifo_best_p1;
    logic [IDX_W-1:0]      w_victim;
    logic                  w_wr_en;
    logic [IDX_W-1:0]      w_wr_idx;
    logic [FRAME_BITS-1:0] w_wr_frame;
    logic                  w_req_acc;
    logic                  w_out_free;

    always_comb begin
        if (r_entries == '0) begin
            w_n = CNT_W'(1);
        end else if (32'(r_entries) > TLB_DEPTH) begin
            w_n = CNT_W'(TLB_DEPTH);
        end else begin
            w_n = CNT_W'(r_entries);
        end
        if (r_page_size == '0) begin
            w_psize = PSIZE_W'(1);
        end else if (r_page_size > PSIZE_MAX) begin
            w_psize = PSIZE_MAX;
        end else begin
            w_psize = r_page_size;
        end
        if (r_rows == '0) begin
            w_rows = ROWS_W'(1);
        end else if (r_rows > ROWS_MAX) begin
            w_rows = ROWS_MAX;
        end else begin
            w_rows = r_rows;
        end
    end

    assign w_rem_sh = {r_rem, r_quo[ADDR_BITS-1]};
    assign w_diff   = w_rem_sh - {1'b0, r_divisor};
    assign w_ge     = !w_diff[DIV_W];
    assign w_rem_nx = w_ge ? w_diff[DIV_W-1:0] : w_rem_sh[DIV_W-1:0];
    assign w_quo_nx = {r_quo[ADDR_BITS-2:0], w_ge};

    assign w_cmp_valid = r_valid[r_cmp_idx];
    assign w_cmp_match = w_cmp_valid && (r_page_rd == r_page);

    assign w_fifo_best    = (CNT_W'(r_fifo_ptr) < w_n) ? r_fifo_ptr : '0;
    assign w_fifo_best_p1 = CNT_W'(w_fifo_best) + CNT_W'(1);
    assign w_victim       = r_lru_mode ? r_min_idx : w_fifo_best;

    always_comb begin
        w_wr_en = (r_state == S_DECIDE) &&
                  ((r_func == FUNC_LOOKUP && r_found) || r_func == FUNC_FILL);
        if (r_found) begin
            w_wr_idx = r_hit_idx;
        end else if (r_free_found) begin
            w_wr_idx = r_free_idx;
        end else begin
            w_wr_idx = w_victim;
        end
        w_wr_frame = (r_func == FUNC_LOOKUP) ? r_hit_frame : r_fill_frame;
    end

    assign w_req_acc  = i_req.valid && i_req.ready;
    assign w_out_free = !r_out_vld || o_rsp.ready;

    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_rsp.valid        = r_out_vld;
    assign o_rsp.hit          = r_out.hit;
    assign o_rsp.frame        = r_out.frame;
    assign o_rsp.page_number  = r_out.page_number;
    assign o_rsp.page_offset  = r_out.page_offset;
    assign o_rsp.level1_index = r_out.level1_index;
    assign o_rsp.level2_index = r_out.level2_index;
    assign o_rsp.walk_root    = r_out.walk_root;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem_page[w_wr_idx]  <= r_page;
            mem_frame[w_wr_idx] <= w_wr_frame;
            mem_age[w_wr_idx]   <= r_use_cnt;
        end
        r_page_rd  <= mem_page[r_idx[IDX_W-1:0]];
        r_frame_rd <= mem_frame[r_idx[IDX_W-1:0]];
        r_age_rd   <= mem_age[r_idx[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_page_size  <= PSIZE_RESET;
            r_rows       <= ROWS_RESET;
            r_lru_mode   <= 1'b0;
            r_entries    <= ENTRIES_RESET;
            r_root_table <= '0;
            r_valid      <= '0;
            r_fifo_ptr   <= '0;
            r_use_cnt    <= '0;
            r_out_vld    <= 1'b0;
            r_cmp_vld    <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (i_cfg.index)
                    CFG_PAGE_SIZE:      r_page_size  <= i_cfg.data[PSIZE_W-1:0];
                    CFG_LEVEL1_ROWS:    r_rows       <= i_cfg.data[ROWS_W-1:0];
                    CFG_LRU_MODE:       r_lru_mode   <= i_cfg.data[0];
                    CFG_ENTRIES_IN_USE: r_entries    <= i_cfg.data[ENTRIES_W-1:0];
                    CFG_ROOT_TABLE:     r_root_table <= i_cfg.data[ROOT_W-1:0];
                    default: ;
                endcase
            end

            if (r_out_vld && o_rsp.ready && r_state != S_DONE) begin
                r_out_vld <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_req_acc) begin
                        r_func       <= i_req.func;
                        r_fill_frame <= i_req.fill_frame;
                        r_res        <= '0;
                        r_quo        <= i_req.logical_address;
                        r_rem        <= '0;
                        r_divisor    <= DIV_W'(w_psize);
                        r_div_cnt    <= DCNT_W'(ADDR_BITS);
                        r_div_second <= 1'b0;
                        if (i_req.func == FUNC_LOOKUP || i_req.func == FUNC_FILL) begin
                            r_state <= S_DIV;
                        end else begin
                            if (i_req.func == FUNC_FLUSH) begin
                                r_valid    <= '0;
                                r_fifo_ptr <= '0;
                            end
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DIV: begin
                    r_quo     <= w_quo_nx;
                    r_rem     <= w_rem_nx;
                    r_div_cnt <= r_div_cnt - DCNT_W'(1);
                    if (r_div_cnt == DCNT_W'(1)) begin
                        if (r_div_second) begin
                            r_res.level1_index <= w_quo_nx;
                            r_res.level2_index <= w_rem_nx[L2_W-1:0];
                            r_state            <= S_DONE;
                        end else begin
                            r_page       <= w_quo_nx;
                            r_offset     <= w_rem_nx[OFFSET_W-1:0];
                            r_idx        <= '0;
                            r_cmp_vld    <= 1'b0;
                            r_found      <= 1'b0;
                            r_free_found <= 1'b0;
                            r_state      <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_idx < w_n) begin
                        r_idx     <= r_idx + CNT_W'(1);
                        r_cmp_vld <= 1'b1;
                        r_cmp_idx <= r_idx[IDX_W-1:0];
                    end else begin
                        r_cmp_vld <= 1'b0;
                        r_state   <= S_DECIDE;
                    end
                    if (r_cmp_vld) begin
                        if (w_cmp_match && !r_found) begin
                            r_found     <= 1'b1;
                            r_hit_idx   <= r_cmp_idx;
                            r_hit_frame <= r_frame_rd;
                        end
                        if (!w_cmp_valid && !r_free_found) begin
                            r_free_found <= 1'b1;
                            r_free_idx   <= r_cmp_idx;
                        end
                        if (r_cmp_idx == '0 || r_age_rd < r_min_age) begin
                            r_min_age <= r_age_rd;
                            r_min_idx <= r_cmp_idx;
                        end
                    end
                end
                S_DECIDE: begin
                    if (r_func == FUNC_LOOKUP) begin
                        r_res.page_number <= r_page;
                        r_res.page_offset <= r_offset;
                        if (r_found) begin
                            r_res.hit   <= 1'b1;
                            r_res.frame <= r_hit_frame;
                            r_use_cnt   <= r_use_cnt + AGE_W'(1);
                            r_state     <= S_DONE;
                        end else begin
                            r_res.walk_root <= r_root_table;
                            r_quo           <= r_page;
                            r_rem           <= '0;
                            r_divisor       <= DIV_W'(w_rows);
                            r_div_cnt       <= DCNT_W'(ADDR_BITS);
                            r_div_second    <= 1'b1;
                            r_state         <= S_DIV;
                        end
                    end else begin
                        r_valid[w_wr_idx] <= 1'b1;
                        r_use_cnt         <= r_use_cnt + AGE_W'(1);
                        if (!r_found && !r_free_found && !r_lru_mode) begin
                            r_fifo_ptr <= (w_fifo_best_p1 < w_n) ?
                                          w_fifo_best_p1[IDX_W-1:0] : '0;
                        end
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out     <= r_res;
                        r_out_vld <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_div_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_divisor))
        else $error("divider remainder reached the divisor");

    a_hit_enabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE && r_found) |-> (CNT_W'(r_hit_idx) < w_n))
        else $error("matching entry lies outside the enabled entries");

    a_rsp_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_state == S_DONE))
        else $error("response loaded outside the final step");

endmodule
